FILE: rtl/rt40_pkg.sv
// ----------------------------------------------------------------------------
// rt40_pkg
// Types, constants and small helper functions shared by the radix-40 word
// tokeniser modules.
// ----------------------------------------------------------------------------
package rt40_pkg;

  // Command limits.
  localparam int unsigned MAX_WORDS      = 20;
  localparam int unsigned CHARS_PER_WORD = 6;

  // Result queue geometry; the depth must be a power of two of at least four.
  localparam int unsigned RQ_DEPTH = 8;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CW    = $clog2(RQ_DEPTH + 1);

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_Z      = 8'h5A;

  // Offsets from a character code to its radix-40 digit.
  localparam logic [7:0] LETTER_BIAS = 8'h40;
  localparam logic [7:0] DIGIT_BIAS  = 8'h12;

  // Place weights within one half word.
  localparam logic [10:0] W_FIRST  = 11'd1600;
  localparam logic [10:0] W_SECOND = 11'd40;
  localparam logic [10:0] W_THIRD  = 11'd1;

  typedef enum logic {
    KIND_WORD   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_ILLEGAL = 2'd2,
    ST_TOOMANY = 2'd3
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] code_high;
    logic [15:0] code_low;
    logic [4:0]  word_index;
    status_e     status;
    logic        last;
  } result_t;

  // Up to two results produced by one character, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

  // Radix-40 digit of a word character, zero when the character is not one.
  function automatic logic [5:0] char_value(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CH_A && c <= CH_Z) begin
      t = c - LETTER_BIAS;
    end else if ((c >= CH_ONE && c <= CH_NINE) || c == CH_HYPHEN) begin
      t = c - DIGIT_BIAS;
    end
    return t[5:0];
  endfunction

  // Weight of the next character, given how many the word already holds.
  function automatic logic [10:0] place_weight(input logic [2:0] n);
    logic [10:0] w;
    case (n)
      3'd0, 3'd3: w = W_FIRST;
      3'd1, 3'd4: w = W_SECOND;
      default:    w = W_THIRD;
    endcase
    return w;
  endfunction

  function automatic result_t status_result(input status_e st);
    result_t r;
    r.kind       = KIND_STATUS;
    r.code_high  = 16'd0;
    r.code_low   = 16'd0;
    r.word_index = 5'd0;
    r.status     = st;
    r.last       = 1'b1;
    return r;
  endfunction

endpackage

FILE: rtl/rt40_ifs.sv
// ----------------------------------------------------------------------------
// rt40 channel interfaces
// Valid/ready channels for incoming characters and outgoing results.
// ----------------------------------------------------------------------------
interface rt40_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface rt40_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [15:0] code_high;
  logic [15:0] code_low;
  logic [4:0]  word_index;
  logic [1:0]  status;
  logic        last_result;

  modport source (output valid, output result_kind, output code_high, output code_low,
                  output word_index, output status, output last_result, input ready);
  modport sink   (input valid, input result_kind, input code_high, input code_low,
                  input word_index, input status, input last_result, output ready);
endinterface

FILE: rtl/radix40_word_tokenizer_core.sv
// ----------------------------------------------------------------------------
// radix40_word_tokenizer_core
// Packs the words of a text command into radix-40 codes, one character per
// transaction, and reports a status at the end of each command.
// ----------------------------------------------------------------------------
// Usage.
// Characters arrive on char_i, one per transaction. Results leave on
// result_o: a word result carries the two packed halves and the word's
// position in its command; a status result closes the command or reports an
// error. last_result marks the final result caused by one character.
// An accepted character is held in the input register, evaluated against
// the word state in the next cycle and written into the result queue at
// the end of that cycle; its first result is then offered on result_o
// straight away. One character is taken every cycle while the receiver
// keeps pace; a terminator that closes a pending word yields two results
// and so takes two transfers on the output. The eight-entry result queue
// sets how far the sender may run ahead of a stalled receiver: char_i.ready
// falls once the queue, counting what the input register may still add,
// could not take two more results. Reset clears the word state, the error
// flag, the input register and the queue; no result is pending afterwards.
// ----------------------------------------------------------------------------
module radix40_word_tokenizer_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  rt40_char_if.sink    char_i,
  rt40_result_if.source result_o
);
  import rt40_pkg::*;

  logic             take;
  logic             pop;
  logic             busy;
  push_t            push;
  result_t          head;
  logic [RQ_CW-1:0] count;
  logic [RQ_CW:0]   reserved;

  // Room is reserved for the worst case of two results from the character
  // in the input register plus two from the one being accepted.
  assign reserved     = (RQ_CW + 1)'(count) + (busy ? (RQ_CW + 1)'(2) : '0);
  assign char_i.ready = reserved <= (RQ_CW + 1)'(RQ_DEPTH - 2);
  assign take         = char_i.valid && char_i.ready;

  rt40_pack u_pack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .char_i (char_i.char_code),
    .busy_o (busy),
    .push_o (push)
  );

  rt40_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (count)
  );

  // The head of the queue drives the output channel directly.
  assign result_o.valid       = count != '0;
  assign pop                  = result_o.valid && result_o.ready;
  assign result_o.result_kind = head.kind;
  assign result_o.code_high   = head.code_high;
  assign result_o.code_low    = head.code_low;
  assign result_o.word_index  = head.word_index;
  assign result_o.status      = head.status;
  assign result_o.last_result = head.last;

  // The reservation rule must keep the queue from ever overfilling.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= RQ_CW'(RQ_DEPTH))
    else $error("result queue overfilled");

  // A status result always closes the results of its character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.result_kind == KIND_STATUS) |-> result_o.last_result)
    else $error("status result not marked last");

  // No word can be numbered beyond the command limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.result_kind == KIND_WORD) |->
      (result_o.word_index < 5'(MAX_WORDS) && result_o.status == ST_OK))
    else $error("word result out of range");

endmodule

FILE: rtl/rt40_pack.sv
// ----------------------------------------------------------------------------
// rt40_pack
// Input register and word state; classifies one character per cycle and
// produces the zero, one or two results that it causes.
// ----------------------------------------------------------------------------
module rt40_pack (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  logic [7:0]      char_i,
  output logic            busy_o,
  output rt40_pkg::push_t push_o
);
  import rt40_pkg::*;

  logic        stage_valid_q;
  logic [7:0]  stage_char_q;
  logic [2:0]  chars_q, chars_d;
  logic [15:0] high_q, high_d;
  logic [15:0] low_q, low_d;
  logic [4:0]  words_q, words_d;
  logic        skip_q, skip_d;

  logic        is_term;
  logic [5:0]  value;
  logic [15:0] product;
  logic [4:0]  words_inc;
  result_t     word_res;
  push_t       push;

  assign is_term   = stage_char_q == CH_NUL || stage_char_q == CH_PERIOD ||
                     stage_char_q == CH_COMMA;
  assign value     = char_value(stage_char_q);
  // The largest digit times the largest weight still fits in 16 bits.
  assign product   = 16'(value) * 16'(place_weight(chars_q));
  assign words_inc = words_q + 5'd1;

  always_comb begin
    word_res.kind       = KIND_WORD;
    word_res.code_high  = high_q;
    word_res.code_low   = low_q;
    word_res.word_index = words_q;
    word_res.status     = ST_OK;
    word_res.last       = 1'b1;
  end

  always_comb begin
    chars_d    = chars_q;
    high_d     = high_q;
    low_d      = low_q;
    words_d    = words_q;
    skip_d     = skip_q;
    push.count = 2'd0;
    push.res0  = word_res;
    push.res1  = status_result(ST_OK);

    if (stage_valid_q) begin
      if (skip_q) begin
        // Dropping input until the end of the line.
        if (stage_char_q == CH_NUL) begin
          skip_d  = 1'b0;
          chars_d = 3'd0;
          high_d  = 16'd0;
          low_d   = 16'd0;
          words_d = 5'd0;
        end
      end else if (is_term) begin
        if (chars_q != 3'd0) begin
          push.count    = 2'd2;
          push.res0     = word_res;
          push.res0.last = 1'b0;
          push.res1     = status_result((words_inc != 5'd0) ? ST_OK : ST_EMPTY);
        end else begin
          push.count = 2'd1;
          push.res0  = status_result((words_q != 5'd0) ? ST_OK : ST_EMPTY);
        end
        chars_d = 3'd0;
        high_d  = 16'd0;
        low_d   = 16'd0;
        words_d = 5'd0;
      end else if (stage_char_q == CH_SPACE) begin
        if (chars_q != 3'd0) begin
          push.count = 2'd1;
          push.res0  = word_res;
          words_d    = words_inc;
          chars_d    = 3'd0;
          high_d     = 16'd0;
          low_d      = 16'd0;
        end
      end else if (value == 6'd0 ||
                   (chars_q == 3'd0 && words_q >= 5'(MAX_WORDS))) begin
        push.count = 2'd1;
        push.res0  = status_result((value == 6'd0) ? ST_ILLEGAL : ST_TOOMANY);
        chars_d    = 3'd0;
        high_d     = 16'd0;
        low_d      = 16'd0;
        words_d    = 5'd0;
        skip_d     = 1'b1;
      end else if (chars_q < 3'(CHARS_PER_WORD)) begin
        if (chars_q < 3'd3) begin
          high_d = high_q + product;
        end else begin
          low_d = low_q + product;
        end
        chars_d = chars_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      chars_q       <= 3'd0;
      high_q        <= 16'd0;
      low_q         <= 16'd0;
      words_q       <= 5'd0;
      skip_q        <= 1'b0;
    end else begin
      stage_valid_q <= take_i;
      chars_q       <= chars_d;
      high_q        <= high_d;
      low_q         <= low_d;
      words_q       <= words_d;
      skip_q        <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      stage_char_q <= char_i;
    end
  end

  assign busy_o = stage_valid_q;
  assign push_o = push;

endmodule

FILE: rtl/rt40_resq.sv
// ----------------------------------------------------------------------------
// rt40_resq
// Result queue: takes up to two results a cycle, hands out one a cycle.
// ----------------------------------------------------------------------------
module rt40_resq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rt40_pkg::push_t              push_i,
  input  logic                         pop_i,
  output rt40_pkg::result_t            head_o,
  output logic [rt40_pkg::RQ_CW-1:0]   count_o
);
  import rt40_pkg::*;

  result_t           mem [RQ_DEPTH];
  logic [RQ_AW-1:0]  wr_q, rd_q;
  logic [RQ_CW-1:0]  count_q;
  logic [RQ_AW-1:0]  wr_next;

  assign wr_next = wr_q + RQ_AW'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem[wr_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem[wr_next] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + RQ_AW'(push_i.count);
      rd_q    <= rd_q + RQ_AW'(pop_i);
      count_q <= count_q + RQ_CW'(push_i.count) - RQ_CW'(pop_i);
    end
  end

  assign head_o  = mem[rd_q];
  assign count_o = count_q;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the radix-40 word tokeniser. A short scripted
// sequence covers the character classes and error paths; random commands
// follow, each result being compared with an in-bench model of the packing.
// ----------------------------------------------------------------------------
module tb_top;
  import rt40_pkg::*;

  // Random stimulus stops once this many characters have been taken.
  localparam int ITEM_TARGET    = 1250;
  // Characters taken after which the receiver is held off, the sender drains
  // the block, and idling stops for the closing stretch.
  localparam int HOLD_AT        = 300;
  localparam int PAUSE_AT       = 700;
  localparam int CALM_AT        = 1100;
  localparam int HOLD_CYCLES    = 64;
  // The first result follows its character through the input register and the result queue; allow a margin.
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SCRIPT_LEN     = 25;

  // Bytes used by the scripted part that the package does not name.
  localparam logic [7:0] CH_AT          = 8'h40;
  localparam logic [7:0] CH_LOWER_A     = 8'h61;
  localparam logic [7:0] CH_DIGIT_ZERO  = 8'h30;
  localparam logic [7:0] CH_TOP         = 8'hFF;

  // One row of the scripted sequence. Where typed is set, the expected result
  // is given in the row itself and replaces what the model would predict.
  typedef struct packed {
    logic [7:0] c;
    logic       typed;
    result_t    r;
  } step_t;

  logic clk_i;
  logic rst_ni;

  rt40_char_if   char_bus ();
  rt40_result_if result_bus ();

  radix40_word_tokenizer_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (char_bus),
    .result_o (result_bus)
  );

  // --------------------------------------------------------------------------
  // Model state: the word being packed and the command it belongs to. It is
  // cleared once, matching the single reset at the start of the run.
  // --------------------------------------------------------------------------
  logic [2:0]  tk_len   = '0;
  logic [15:0] tk_hi    = '0;
  logic [15:0] tk_lo    = '0;
  logic [4:0]  tk_words = '0;
  logic        tk_skip  = 1'b0;

  result_t     fresh[$];        // results caused by the character just taken
  result_t     tokens_due[$];   // results still owed by the block, oldest first
  step_t       script_notes[$]; // scripted rows offered but not yet accepted
  step_t       script [SCRIPT_LEN];
  logic [7:0]  line_q[$];       // bytes of the command being sent

  int          mismatches   = 0;
  int          live_chars   = 0;
  int          sent_chars   = 0;
  int          word_results = 0;
  int          status_seen [4] = '{0, 0, 0, 0};
  bit          calm         = 1'b0;
  bit          hold_req     = 1'b0;
  bit          send_quiet   = 1'b0;
  bit          sink_quiet   = 1'b0;

  // --------------------------------------------------------------------------
  // Clock and reset. Reset is applied once, at the start of the run.
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Model of the packing.
  // --------------------------------------------------------------------------

  // Radix-40 digit of a word character; zero for anything else.
  function automatic logic [5:0] radix_digit(input logic [7:0] c);
    logic [5:0] d;
    d = '0;
    if (c >= CH_A && c <= CH_Z) begin
      d = 6'(c - LETTER_BIAS);
    end else if (c >= CH_ONE && c <= CH_NINE) begin
      d = 6'(c - DIGIT_BIAS);
    end else if (c == CH_HYPHEN) begin
      d = 6'(c - DIGIT_BIAS);
    end
    return d;
  endfunction

  function automatic bit is_separator(input logic [7:0] c);
    return c == CH_NUL || c == CH_PERIOD || c == CH_COMMA || c == CH_SPACE;
  endfunction

  function automatic result_t status_tok(input status_e st);
    result_t r;
    r            = '0;
    r.kind       = KIND_STATUS;
    r.status     = st;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic result_t word_tok(input logic [15:0] hi, input logic [15:0] lo,
                                       input logic [4:0] idx);
    result_t r;
    r            = '0;
    r.kind       = KIND_WORD;
    r.code_high  = hi;
    r.code_low   = lo;
    r.word_index = idx;
    r.status     = ST_OK;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic void drop_command();
    tk_len   = '0;
    tk_hi    = '0;
    tk_lo    = '0;
    tk_words = '0;
  endfunction

  function automatic void close_word();
    fresh.push_back(word_tok(tk_hi, tk_lo, tk_words));
    tk_words = tk_words + 5'd1;
    tk_len   = '0;
    tk_hi    = '0;
    tk_lo    = '0;
  endfunction

  // Works out the results of one character into fresh and advances the state.
  function automatic void pack_char(input logic [7:0] c);
    logic [5:0]  d;
    logic [15:0] w;
    d = radix_digit(c);
    fresh.delete();
    // After an error everything up to the end of the line is dropped; the
    // zero byte that ends the line is itself silent.
    if (tk_skip) begin
      if (c == CH_NUL) begin
        tk_skip = 1'b0;
        drop_command();
      end
      return;
    end
    live_chars++;
    if (c == CH_NUL || c == CH_PERIOD || c == CH_COMMA) begin
      if (tk_len != 0) close_word();
      fresh.push_back(status_tok((tk_words != 0) ? ST_OK : ST_EMPTY));
      drop_command();
    end else if (c == CH_SPACE) begin
      // A space with nothing pending is simply absorbed.
      if (tk_len != 0) close_word();
    end else if (d == 0) begin
      fresh.push_back(status_tok(ST_ILLEGAL));
      drop_command();
      tk_skip = 1'b1;
    end else if (tk_len == 0 && tk_words >= MAX_WORDS) begin
      fresh.push_back(status_tok(ST_TOOMANY));
      drop_command();
      tk_skip = 1'b1;
    end else if (tk_len < CHARS_PER_WORD) begin
      // Characters beyond the sixth are accepted but change nothing.
      case (tk_len % 3)
        0:       w = 16'(W_FIRST);
        1:       w = 16'(W_SECOND);
        default: w = 16'(W_THIRD);
      endcase
      if (tk_len < 3) begin
        tk_hi = tk_hi + 16'(d) * w;
      end else begin
        tk_lo = tk_lo + 16'(d) * w;
      end
      tk_len = tk_len + 3'd1;
    end
    foreach (fresh[i]) fresh[i].last = (i == fresh.size() - 1);
  endfunction

  // --------------------------------------------------------------------------
  // Checking.
  // --------------------------------------------------------------------------
  task automatic report(input string msg);
    if (mismatches < 40) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // A character has been taken: predict its results, or use the scripted
  // row's own expectation where it carries one.
  task automatic take_char(input logic [7:0] c);
    step_t note;
    sent_chars++;
    pack_char(c);
    if (script_notes.size() != 0) begin
      note = script_notes.pop_front();
      if (note.typed) begin
        fresh.delete();
        fresh.push_back(note.r);
      end
    end
    foreach (fresh[i]) tokens_due.push_back(fresh[i]);
  endtask

  task automatic check_result();
    result_t want;
    if (tokens_due.size() == 0) begin
      report($sformatf("result kind %0d high %0d low %0d status %0d with nothing outstanding",
                       result_bus.result_kind, result_bus.code_high, result_bus.code_low,
                       result_bus.status));
      return;
    end
    want = tokens_due.pop_front();
    if (result_bus.result_kind !== want.kind)
      report($sformatf("result_kind %0d, expected %0d", result_bus.result_kind, want.kind));
    if (result_bus.code_high !== want.code_high)
      report($sformatf("code_high %0d, expected %0d", result_bus.code_high, want.code_high));
    if (result_bus.code_low !== want.code_low)
      report($sformatf("code_low %0d, expected %0d", result_bus.code_low, want.code_low));
    if (result_bus.word_index !== want.word_index)
      report($sformatf("word_index %0d, expected %0d", result_bus.word_index,
                       want.word_index));
    if (result_bus.status !== want.status)
      report($sformatf("status %0d, expected %0d", result_bus.status, want.status));
    if (result_bus.last_result !== want.last)
      report($sformatf("last_result %0d, expected %0d", result_bus.last_result, want.last));
    if (want.kind == KIND_WORD) word_results++;
    else status_seen[int'(want.status)]++;
  endtask

  // Both channels are sampled at the rising edge, before the block's own
  // registers and the bench's nonblocking drives take effect.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (char_bus.valid && char_bus.ready) take_char(char_bus.char_code);
      if (result_bus.valid && result_bus.ready) check_result();
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  function automatic step_t plain(input logic [7:0] c);
    step_t s;
    s       = '0;
    s.c     = c;
    return s;
  endfunction

  function automatic step_t typed_step(input logic [7:0] c, input result_t r);
    step_t s;
    s       = plain(c);
    s.typed = 1'b1;
    s.r     = r;
    return s;
  endfunction

  function automatic logic [7:0] word_char();
    int unsigned r;
    r = $urandom_range(0, 35);
    if (r < 26) return CH_A + 8'(r);
    if (r < 35) return CH_ONE + 8'(r - 26);
    return CH_HYPHEN;
  endfunction

  // Any byte that is neither a word character nor a separator.
  function automatic logic [7:0] junk_char();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (radix_digit(b) != 0 || is_separator(b));
    return b;
  endfunction

  // Builds one command in line_q. Most are well formed with random words;
  // some carry a stray byte, and a few are plain noise. Long commands run
  // either side of the word limit.
  task automatic queue_command(input bit long_cmd);
    int pick;
    int n_words;
    int len;
    int bad_at;
    int w;
    int k;
    pick = $urandom_range(0, 99);
    if (!long_cmd && pick < 10) begin
      repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) != 0) line_q.push_back(CH_NUL);
      return;
    end
    if (long_cmd || $urandom_range(0, 9) == 0) n_words = $urandom_range(19, 23);
    else n_words = $urandom_range(0, 5);
    bad_at = (pick < 20) ? $urandom_range(0, n_words) : -1;
    if ($urandom_range(0, 3) == 0) line_q.push_back(CH_SPACE);
    for (w = 0; w < n_words; w++) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 9) : $urandom_range(1, 6);
      for (k = 0; k < len; k++) line_q.push_back(word_char());
      if (w == bad_at) line_q.push_back(junk_char());
      if (w < n_words - 1 || $urandom_range(0, 1) != 0)
        repeat ($urandom_range(1, 2)) line_q.push_back(CH_SPACE);
    end
    if (bad_at == n_words) line_q.push_back(junk_char());
    case ($urandom_range(0, 2))
      0:       line_q.push_back(CH_NUL);
      1:       line_q.push_back(CH_PERIOD);
      default: line_q.push_back(CH_COMMA);
    endcase
  endtask

  // Offers one character and returns at the edge that takes it. A gap, when
  // one is drawn, lowers valid and waits out the gap first, so valid is never
  // lowered and raised within the same step.
  task automatic offer(input logic [7:0] c);
    int gap;
    if ($urandom_range(0, 99) == 0) send_quiet = !send_quiet;
    if (!calm && !send_quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      char_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= c;
    do @(posedge clk_i); while (char_bus.ready !== 1'b1);
  endtask

  // Sender: scripted rows, then random commands until enough characters
  // have gone through, then drain and finish.
  initial begin : sender
    bit held;
    bit paused;
    bit first;
    held                = 1'b0;
    paused              = 1'b0;
    first               = 1'b1;
    char_bus.valid      = 1'b0;
    char_bus.char_code  = CH_NUL;

    // Expected results are typed in where they are plain: empty commands,
    // a full word of Z (26 * 1600 + 26 * 40 + 26 in each half) and the
    // illegal bytes 8'hFF, 8'h40 below A, lower-case a and the digit zero.
    script = '{
      typed_step(CH_PERIOD, status_tok(ST_EMPTY)),
      typed_step(CH_COMMA, status_tok(ST_EMPTY)),
      plain(CH_Z), plain(CH_Z), plain(CH_Z), plain(CH_Z), plain(CH_Z), plain(CH_Z),
      plain(CH_Z),
      typed_step(CH_SPACE, word_tok(16'd42666, 16'd42666, 5'd0)),
      plain(CH_SPACE),
      plain(CH_A), plain(CH_HYPHEN), plain(CH_NINE), plain(CH_ONE),
      plain(CH_NUL),
      typed_step(CH_TOP, status_tok(ST_ILLEGAL)),
      plain(CH_A), plain(CH_NUL),
      typed_step(CH_AT, status_tok(ST_ILLEGAL)), plain(CH_NUL),
      typed_step(CH_LOWER_A, status_tok(ST_ILLEGAL)), plain(CH_NUL),
      typed_step(CH_DIGIT_ZERO, status_tok(ST_ILLEGAL)), plain(CH_NUL)
    };

    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    foreach (script[i]) begin
      script_notes.push_back(script[i]);
      offer(script[i].c);
    end

    while (sent_chars < ITEM_TARGET) begin
      // Starve the result side for a long stretch while characters keep
      // coming, so the result queue fills and the input stalls.
      if (!held && sent_chars >= HOLD_AT) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      // Once, stop sending until the block owes nothing.
      if (!paused && sent_chars >= PAUSE_AT) begin
        paused = 1'b1;
        char_bus.valid <= 1'b0;
        @(posedge clk_i);
        while (tokens_due.size() != 0) @(posedge clk_i);
      end
      if (sent_chars >= CALM_AT) calm = 1'b1;
      // The first random command is long, drawn either side of the word limit.
      queue_command(first);
      first = 1'b0;
      while (line_q.size() != 0) offer(line_q.pop_front());
    end

    char_bus.valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d characters (%0d outside skipped lines), %0d word results",
             sent_chars, live_chars, word_results);
    $display("status results: ok %0d, empty %0d, illegal %0d, too many words %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Receiver: random stalls in bursts, quiet stretches, one long hold-off on
  // request, and no stalls at all in the closing stretch.
  initial begin : receiver
    int n;
    result_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 149) == 0) sink_quiet = !sink_quiet;
      if (hold_req) begin
        hold_req = 1'b0;
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else if (!calm && !sink_quiet && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 8);
        result_bus.ready <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((char_bus.valid && char_bus.ready) || (result_bus.valid && result_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout after %0d cycles without a transaction", WATCHDOG_LIMIT);
    $display("tb_top: errors");
    $finish;
  end

endmodule
